>>> hw/rtl/kss_pkg.sv
package kss_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIV_RD,
    ST_PIV,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_FIX_RD,
    ST_FIX_A,
    ST_FIX_B,
    ST_SEL_RD,
    ST_SEL_WAIT,
    ST_RESULT
  } state_t;

  localparam int unsigned ElemWidth = 64;
  localparam int unsigned RankWidth = 11;

  typedef logic [ElemWidth-1:0] elem_t;
  typedef logic [RankWidth-1:0] rank_t;

endpackage

>>> hw/rtl/kss_if.sv
interface kss_elem_if;
  logic             valid;
  logic             ready;
  kss_pkg::elem_t   element_bits;
  logic             last_element;
  modport source (output valid, element_bits, last_element, input ready);
  modport sink (input valid, element_bits, last_element, output ready);
endinterface

interface kss_result_if;
  logic             valid;
  logic             ready;
  kss_pkg::elem_t   selected_bits;
  logic             rank_error;
  modport source (output valid, selected_bits, rank_error, input ready);
  modport sink (input valid, selected_bits, rank_error, output ready);
endinterface

interface kss_cfg_if;
  logic             valid;
  logic             ready;
  kss_pkg::rank_t   rank;
  modport source (output valid, rank, input ready);
  modport sink (input valid, rank, output ready);
endinterface

>>> hw/rtl/kss_mem.sv
module kss_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW = 10
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  kss_pkg::elem_t wdata,
  input  logic [AW-1:0]  raddr,
  output kss_pkg::elem_t rdata
);

  kss_pkg::elem_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/kss_fcmp.sv
// a <= b in IEEE double order; NaN never compares true
module kss_fcmp (
  input  kss_pkg::elem_t a,
  input  kss_pkg::elem_t b,
  output logic           le
);

  logic a_nan, b_nan, both_zero, mag_le, mag_ge;

  always_comb begin
    a_nan     = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    b_nan     = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
    mag_le    = a[62:0] <= b[62:0];
    mag_ge    = a[62:0] >= b[62:0];
    if (a_nan || b_nan) begin
      le = 1'b0;
    end else if (both_zero) begin
      le = 1'b1;
    end else if (a[63] != b[63]) begin
      le = a[63];
    end else if (a[63]) begin
      le = mag_ge;
    end else begin
      le = mag_le;
    end
  end

endmodule

>>> hw/rtl/kth_smallest_select_unit.sv
// Loads a set of IEEE doubles, one transfer per cycle, then returns the rank-th
// smallest by quickselect with Lomuto partitioning (pivot = last element of the
// range). Input is held off from the last element until the result is staged.
// All work goes through one simple dual-port store (one read, one write per
// cycle, registered read) and one double compare unit. Each partition pass
// fetches the pivot, reads and compares each scanned element, swaps it into
// place when needed, and then places the pivot; the final fetch reads the
// target. An error result (rank 0, rank above count, or more than MAX_ELEMENTS
// loaded) is staged via ST_RESULT after the last element, with selected_bits of zero.
module kth_smallest_select_unit #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  kss_elem_if.sink          elements,
  kss_result_if.source      result,
  kss_cfg_if.sink           cfg
);

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned RW = (CW > kss_pkg::RankWidth) ? CW : kss_pkg::RankWidth;

  kss_pkg::state_t state, state_next;
  kss_pkg::rank_t  rank;
  logic [CW-1:0]   count, count_inc;
  logic            overflow, overflow_inc, err;
  logic [AW-1:0]   low, high, sidx, scan, target;
  logic [AW-1:0]   low_next, high_next, sidx_next, scan_next, target_next;
  kss_pkg::elem_t  pivot, pivot_next, sval, sval_next;
  kss_pkg::elem_t  out_bits, out_bits_next;
  logic            out_err, out_err_next, out_valid, out_valid_next;
  logic            pend_err, pend_err_next;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  kss_pkg::elem_t  wdata, rdata;
  logic            le;
  logic            in_xfer;

  kss_mem #(.DEPTH(MAX_ELEMENTS), .AW(AW)) u_mem (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  kss_fcmp u_cmp (.a(rdata), .b(pivot), .le);

  assign cfg.ready            = 1'b1;
  assign elements.ready       = (state == kss_pkg::ST_IDLE);
  assign in_xfer              = elements.valid && elements.ready;
  assign result.valid         = out_valid;
  assign result.selected_bits = out_bits;
  assign result.rank_error    = out_err;

  always_comb begin
    if (count < CW'(MAX_ELEMENTS)) begin
      count_inc    = count + CW'(1);
      overflow_inc = overflow;
    end else begin
      count_inc    = count;
      overflow_inc = 1'b1;
    end
    err = overflow_inc || (rank == '0) || (RW'(rank) > RW'(count_inc));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank <= kss_pkg::rank_t'(1);
    end else if (cfg.valid) begin
      rank <= cfg.rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kss_pkg::ST_IDLE;
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (in_xfer) begin
        count    <= elements.last_element ? '0 : count_inc;
        overflow <= elements.last_element ? 1'b0 : overflow_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    low      <= low_next;
    high     <= high_next;
    sidx     <= sidx_next;
    scan     <= scan_next;
    target   <= target_next;
    pivot    <= pivot_next;
    sval     <= sval_next;
    pend_err <= pend_err_next;
    out_bits <= out_bits_next;
    out_err  <= out_err_next;
  end

  always_comb begin
    state_next     = state;
    low_next       = low;
    high_next      = high;
    sidx_next      = sidx;
    scan_next      = scan;
    target_next    = target;
    pivot_next     = pivot;
    sval_next      = sval;
    pend_err_next  = pend_err;
    out_bits_next  = out_bits;
    out_err_next   = out_err;
    out_valid_next = out_valid && !result.ready;
    we             = 1'b0;
    waddr          = count[AW-1:0];
    wdata          = elements.element_bits;
    raddr          = scan;
    unique case (state)
      kss_pkg::ST_IDLE: begin
        if (in_xfer) begin
          we = (count < CW'(MAX_ELEMENTS));
          if (elements.last_element) begin
            low_next    = '0;
            high_next   = AW'(count_inc - CW'(1));
            target_next = AW'(RW'(rank) - RW'(1));
            if (err) begin
              sval_next     = '0;
              pend_err_next = 1'b1;
              state_next    = kss_pkg::ST_RESULT;
            end else if (count_inc > CW'(1)) begin
              state_next = kss_pkg::ST_PIV_RD;
            end else begin
              state_next = kss_pkg::ST_SEL_RD;
            end
          end
        end
      end
      kss_pkg::ST_PIV_RD: begin
        raddr      = high;
        state_next = kss_pkg::ST_PIV;
      end
      kss_pkg::ST_PIV: begin
        pivot_next = rdata;
        sidx_next  = low;
        scan_next  = low;
        state_next = kss_pkg::ST_SCAN_RD;
      end
      kss_pkg::ST_SCAN_RD: begin
        raddr      = scan;
        state_next = (scan == high) ? kss_pkg::ST_FIX_RD : kss_pkg::ST_SCAN_CMP;
      end
      kss_pkg::ST_SCAN_CMP: begin
        sval_next = rdata;
        raddr     = sidx;
        if (le && (sidx != scan)) begin
          state_next = kss_pkg::ST_SWAP_A;
        end else begin
          if (le) begin
            sidx_next = sidx + AW'(1);
          end
          scan_next  = scan + AW'(1);
          state_next = kss_pkg::ST_SCAN_RD;
        end
      end
      kss_pkg::ST_SWAP_A: begin
        we         = 1'b1;
        waddr      = scan;
        wdata      = rdata;
        state_next = kss_pkg::ST_SWAP_B;
      end
      kss_pkg::ST_SWAP_B: begin
        we         = 1'b1;
        waddr      = sidx;
        wdata      = sval;
        sidx_next  = sidx + AW'(1);
        scan_next  = scan + AW'(1);
        state_next = kss_pkg::ST_SCAN_RD;
      end
      kss_pkg::ST_FIX_RD: begin
        raddr      = sidx;
        state_next = kss_pkg::ST_FIX_A;
      end
      kss_pkg::ST_FIX_A: begin
        we         = 1'b1;
        waddr      = high;
        wdata      = rdata;
        state_next = kss_pkg::ST_FIX_B;
      end
      kss_pkg::ST_FIX_B: begin
        we    = 1'b1;
        waddr = sidx;
        wdata = pivot;
        if (sidx == target) begin
          state_next = kss_pkg::ST_SEL_RD;
        end else if (target < sidx) begin
          high_next  = sidx - AW'(1);
          state_next = (low < sidx - AW'(1)) ? kss_pkg::ST_PIV_RD : kss_pkg::ST_SEL_RD;
        end else begin
          low_next   = sidx + AW'(1);
          state_next = (sidx + AW'(1) < high) ? kss_pkg::ST_PIV_RD : kss_pkg::ST_SEL_RD;
        end
      end
      kss_pkg::ST_SEL_RD: begin
        raddr      = target;
        state_next = kss_pkg::ST_SEL_WAIT;
      end
      kss_pkg::ST_SEL_WAIT: begin
        sval_next     = rdata;
        pend_err_next = 1'b0;
        state_next    = kss_pkg::ST_RESULT;
      end
      kss_pkg::ST_RESULT: begin
        if (!out_valid || result.ready) begin
          out_bits_next  = sval;
          out_err_next   = pend_err;
          out_valid_next = 1'b1;
          state_next     = kss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kss_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/kss_checker.sv
module kss_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input logic           in_last,
  input logic           out_valid,
  input logic           out_ready,
  input kss_pkg::elem_t out_bits,
  input logic           out_err
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_bits) && $stable(out_err))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_err |-> out_bits == '0)
    else $error("error result with nonzero value");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken during selection");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind kth_smallest_select_unit kss_checker u_kss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (elements.valid),
  .in_ready  (elements.ready),
  .in_last   (elements.last_element),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_bits  (result.selected_bits),
  .out_err   (result.rank_error)
);
